### rtl/line_rasterizer_with_pixel_address_assert.svh
`ifndef LINE_RASTERIZER_WITH_PIXEL_ADDRESS_ASSERT_SVH
`define LINE_RASTERIZER_WITH_PIXEL_ADDRESS_ASSERT_SVH

// same-cycle implication, off during reset
`define LRPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LRPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define LRPA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lrpa_pkg.sv
`default_nettype none
package lrpa_pkg;
  localparam int COORD_BITS = 10;
  localparam int CW = COORD_BITS;
  localparam int COLOR_BITS = 16;
  localparam int IDXW = 2 * CW;
  localparam int VW = 2 * CW + 3;
  localparam int EW = CW + 2;

  localparam int IN_FIELD_BITS = 4 * CW + COLOR_BITS;
  localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * CW + IDXW + COLOR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REG_ORIENT = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] ORIENT_ROT90 = 2'd0;
  localparam logic [1:0] ORIENT_NONE = 2'd1;
  localparam logic [1:0] ORIENT_ROT180 = 2'd2;
  localparam logic [1:0] ORIENT_OFF = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] ORIENT_RST = ORIENT_NONE;
  localparam logic [CW-1:0] WIDTH_RST = CW'(480);
  localparam logic [CW-1:0] HEIGHT_RST = CW'(272);

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic last;
  } pix_t;

  typedef struct packed {
    logic [1:0] orient;
    logic [CW-1:0] width;
    logic [CW-1:0] height;
  } cfg_t;
endpackage
`default_nettype wire

### rtl/lrpa_front.sv
`default_nettype none
module lrpa_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic cmd,
  input  wire logic [lrpa_pkg::CW-1:0] x0,
  input  wire logic [lrpa_pkg::CW-1:0] y0,
  input  wire logic [lrpa_pkg::CW-1:0] x1,
  input  wire logic [lrpa_pkg::CW-1:0] y1,
  input  wire logic [lrpa_pkg::COLOR_BITS-1:0] color,
  input  wire logic fifo_full,
  output logic push,
  output lrpa_pkg::pix_t push_data
);
  import lrpa_pkg::*;

  logic [CW-1:0] cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic [CW-1:0] cur_x_nxt, cur_y_nxt, end_x_nxt, end_y_nxt;
  logic [CW:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic active_r, active_nxt;

  logic accept, fin;
  logic [CW:0] ldx, ldy;
  logic signed [EW:0] e_ext, ndx, pdy, e_upd;

  assign in_ready = !fifo_full;
  assign accept = in_valid && in_ready;
  assign fin = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  assign push = accept && (cmd == CMD_STEP) && active_r;

  always_comb begin
    push_data.x = cur_x_r;
    push_data.y = cur_y_r;
    push_data.color = color_r;
    push_data.last = fin;
  end

  assign ldx = (x0 < x1) ? ({1'b0, x1} - {1'b0, x0}) : ({1'b0, x0} - {1'b0, x1});
  assign ldy = (y0 < y1) ? ({1'b0, y1} - {1'b0, y0}) : ({1'b0, y0} - {1'b0, y1});
  assign e_ext = {err_r[EW-1], err_r};
  assign ndx = -$signed({2'b00, dx_r});
  assign pdy = $signed({2'b00, dy_r});

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    end_x_nxt = end_x_r;
    end_y_nxt = end_y_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    sxn_nxt = sxn_r;
    syn_nxt = syn_r;
    err_nxt = err_r;
    color_nxt = color_r;
    active_nxt = active_r;
    e_upd = e_ext;
    if (accept && cmd == CMD_LOAD) begin
      cur_x_nxt = x0;
      cur_y_nxt = y0;
      end_x_nxt = x1;
      end_y_nxt = y1;
      dx_nxt = ldx;
      dy_nxt = ldy;
      sxn_nxt = !(x0 < x1);
      syn_nxt = !(y0 < y1);
      if (ldx > ldy) begin
        err_nxt = $signed({2'b00, ldx[CW:1]});
      end else begin
        err_nxt = -$signed({2'b00, ldy[CW:1]});
      end
      color_nxt = color;
      active_nxt = 1'b1;
    end else if (push) begin
      if (fin) begin
        active_nxt = 1'b0;
      end else begin
        if (e_ext > ndx) begin
          e_upd = e_upd - pdy;
          cur_x_nxt = sxn_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
        end
        if (e_ext < pdy) begin
          e_upd = e_upd + $signed({2'b00, dx_r});
          cur_y_nxt = syn_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
        end
        err_nxt = e_upd[EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    end_x_r <= end_x_nxt;
    end_y_r <= end_y_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    sxn_r <= sxn_nxt;
    syn_r <= syn_nxt;
    err_r <= err_nxt;
    color_r <= color_nxt;
  end
endmodule
`default_nettype wire

### rtl/lrpa_fifo.sv
`default_nettype none
module lrpa_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire lrpa_pkg::pix_t push_data,
  output logic full,
  input  wire logic pop,
  output lrpa_pkg::pix_t pop_data,
  output logic empty
);
  import lrpa_pkg::*;

  pix_t mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wp_r, rp_r;
  logic [FIFO_PW:0] cnt_r;

  assign full = (cnt_r == (FIFO_PW + 1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_PW'(1);
      end
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + (FIFO_PW + 1)'(1);
        2'b01: cnt_r <= cnt_r - (FIFO_PW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

### rtl/lrpa_back.sv
`default_nettype none
module lrpa_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire lrpa_pkg::cfg_t cfg,
  input  wire logic fifo_empty,
  input  wire lrpa_pkg::pix_t pop_data,
  output logic pop,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [lrpa_pkg::CW-1:0] out_x,
  output logic [lrpa_pkg::CW-1:0] out_y,
  output logic [lrpa_pkg::IDXW-1:0] out_index,
  output logic [lrpa_pkg::COLOR_BITS-1:0] out_color,
  output logic out_we,
  output logic out_last
);
  import lrpa_pkg::*;

  logic [IDXW-1:0] total_r;
  logic s1_valid_r, s2_valid_r;
  pix_t s1_pix_r;
  logic signed [VW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] add_r, add_nxt;
  logic plus_r, off_r;
  logic s1_en, s2_en;
  logic signed [CW+1:0] mul_a;
  logic signed [VW-1:0] total_m1, v;
  logic in_frame;
  logic [IDXW-1:0] idx_nxt;
  logic we_nxt;

  pix_t s2_pix_r;
  logic [IDXW-1:0] idx_r;
  logic we_r;

  assign s2_en = !s2_valid_r || out_ready;
  assign s1_en = !s1_valid_r || s2_en;
  assign pop = !fifo_empty && s1_en;

  always_comb begin
    if (cfg.orient == ORIENT_ROT90) begin
      mul_a = $signed({2'b00, cfg.height} - (CW + 2)'(1) - {2'b00, pop_data.x});
    end else begin
      mul_a = $signed({2'b00, pop_data.y});
    end
    prod_nxt = VW'(mul_a) * VW'($signed({1'b0, cfg.width}));
    add_nxt = (cfg.orient == ORIENT_ROT180) ? pop_data.x : pop_data.y;
  end

  always_comb begin
    total_m1 = $signed({3'b000, total_r}) - VW'(1);
    if (plus_r) begin
      v = prod_r + $signed({{(VW - CW){1'b0}}, s1_pix_r.x});
    end else begin
      v = total_m1 - $signed({{(VW - CW){1'b0}}, add_r}) - prod_r;
    end
    in_frame = !v[VW-1] && ($unsigned(v) < {3'b000, total_r});
    we_nxt = in_frame && !off_r;
    idx_nxt = we_nxt ? v[IDXW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= !fifo_empty;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
    end
    total_r <= IDXW'(cfg.width) * IDXW'(cfg.height);
    if (s1_en) begin
      s1_pix_r <= pop_data;
      prod_r <= prod_nxt;
      add_r <= add_nxt;
      plus_r <= (cfg.orient == ORIENT_NONE);
      off_r <= (cfg.orient == ORIENT_OFF);
    end
    if (s2_en) begin
      s2_pix_r <= s1_pix_r;
      idx_r <= idx_nxt;
      we_r <= we_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_x = s2_pix_r.x;
  assign out_y = s2_pix_r.y;
  assign out_index = idx_r;
  assign out_color = s2_pix_r.color;
  assign out_we = we_r;
  assign out_last = s2_pix_r.last;
endmodule
`default_nettype wire

### rtl/line_rasterizer_with_pixel_address.sv
// Bresenham line rasterizer. A load transaction (tuser 0) latches a line's endpoints and
// color and returns nothing; each step transaction (tuser 1) returns the current pixel with
// its frame-buffer index for the programmed orientation, then advances one step. A step with
// no line loaded returns nothing. The stepper takes one transaction per clock while the
// queue is not full; a four-entry queue feeds a two-stage index pipeline (one multiply
// stage, one add/compare stage) ending in the output register, and one pixel per clock
// flows while out_tready is high. Registers at byte address 0 orientation, 4 width, 8
// height; program them only while no line is in flight.
`default_nettype none
module line_rasterizer_with_pixel_address (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // x_start, y_start, x_end, y_end, pixel_color
  input  wire logic [lrpa_pkg::IN_DATA_BITS-1:0] in_tdata,
  // cmd
  input  wire logic in_tuser,
  output logic out_tvalid,
  input  wire logic out_tready,
  // pixel_x, pixel_y, pixel_index, color_out
  output logic [lrpa_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // write_enable
  output logic out_tuser,
  output logic out_tlast,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [lrpa_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [lrpa_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [lrpa_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic cfg_pready
);
  import lrpa_pkg::*;

  cfg_t cfg_r;
  logic cfg_wr;
  logic [1:0] reg_sel;
  logic push, fifo_full, fifo_empty, pop;
  pix_t push_data, pop_data;
  logic [CW-1:0] o_x, o_y;
  logic [IDXW-1:0] o_idx;
  logic [COLOR_BITS-1:0] o_color;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[3:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orient <= ORIENT_RST;
      cfg_r.width <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ORIENT: cfg_r.orient <= cfg_pwdata[1:0];
        REG_WIDTH: cfg_r.width <= cfg_pwdata[CW-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_pwdata[CW-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (reg_sel)
      REG_ORIENT: cfg_prdata[1:0] = cfg_r.orient;
      REG_WIDTH: cfg_prdata[CW-1:0] = cfg_r.width;
      REG_HEIGHT: cfg_prdata[CW-1:0] = cfg_r.height;
      default: cfg_prdata = '0;
    endcase
  end

  lrpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .x0        (in_tdata[CW-1:0]),
    .y0        (in_tdata[2*CW-1:CW]),
    .x1        (in_tdata[3*CW-1:2*CW]),
    .y1        (in_tdata[4*CW-1:3*CW]),
    .color     (in_tdata[4*CW+COLOR_BITS-1:4*CW]),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  lrpa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  lrpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_x      (o_x),
    .out_y      (o_y),
    .out_index  (o_idx),
    .out_color  (o_color),
    .out_we     (out_tuser),
    .out_last   (out_tlast)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[CW-1:0] = o_x;
    out_tdata[2*CW-1:CW] = o_y;
    out_tdata[2*CW+IDXW-1:2*CW] = o_idx;
    out_tdata[2*CW+IDXW+COLOR_BITS-1:2*CW+IDXW] = o_color;
  end
endmodule
`default_nettype wire

### rtl/lrpa_checker.sv
`default_nettype none
`include "line_rasterizer_with_pixel_address_assert.svh"
module lrpa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [lrpa_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input wire logic out_tuser
);
  import lrpa_pkg::*;

  logic [IDXW-1:0] idx_seen;

  assign idx_seen = out_tdata[2*CW+IDXW-1:2*CW];

  `LRPA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `LRPA_ASSERT_NOW(a_idx_zero, out_tvalid && !out_tuser, idx_seen == '0, "index not zero")
  `LRPA_ASSERT_RST(a_rst_idle, !rst_n, !out_tvalid, "result after reset")
endmodule

bind line_rasterizer_with_pixel_address lrpa_checker u_lrpa_checker (.*);
`default_nettype wire
